[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IRPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IRPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/irpw_pkg.sv]
// ----------------------------------------------------------------------------
// irpw_pkg
// Types, codes and reset constants of the infrared pulse-width frame capture.
// ----------------------------------------------------------------------------
`default_nettype none

package irpw_pkg;

	localparam int TICK_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_CFG    = 8;
	localparam int FRAME_W    = 64;
	localparam int CODE_W     = 2;
	localparam int COUNT_W    = 7;
	localparam int CD_W       = 5;
	localparam int SHIFT_W    = 3;
	localparam int QUEUE_DEPTH = 4;

	// defaults for top-level parameters
	localparam int DEF_SPIKE_MAX     = 2400;
	localparam int DEF_RELEASE_TICKS = 18;
	localparam int DEF_CAPTURE_BITS  = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
	localparam logic [COUNT_W-1:0] FULL_FRAME = 7'd51;

	// frame end codes
	localparam logic [CODE_W-1:0] END_PULSE   = 2'd0;
	localparam logic [CODE_W-1:0] END_IDLE    = 2'd1;
	localparam logic [CODE_W-1:0] END_RELEASE = 2'd2;

	localparam logic [FRAME_W-1:0] RELEASE_WORD = 64'h1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_T_MIN   = 3'd0,
		REG_ONE_T_MAX   = 3'd1,
		REG_TWO_T_MIN   = 3'd2,
		REG_TWO_T_MAX   = 3'd3,
		REG_THREE_T_MIN = 3'd4,
		REG_THREE_T_MAX = 3'd5,
		REG_SIX_T_MIN   = 3'd6,
		REG_SIX_T_MAX   = 3'd7
	} reg_idx_t;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
		16'd2989, 16'd7895, 16'd8055, 16'd13495,
		16'd13498, 16'd18875, 16'd26142, 16'd40316
	};

	// item classes decided by the front end
	typedef enum logic [2:0] {
		CLS_ONE   = 3'd0,
		CLS_TWO   = 3'd1,
		CLS_THREE = 3'd2,
		CLS_SIX   = 3'd3,
		CLS_SPIKE = 3'd4,
		CLS_LONG  = 3'd5,
		CLS_IDLE  = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t cls;
	} q_entry_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/irpw_ifs.sv]
// ----------------------------------------------------------------------------
// irpw channel interfaces
// Valid/ready channels for pulse items in and frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface irpw_in_if;
	import irpw_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TICK_W-1:0] pulse_ticks;

	modport source (output valid, kind, pulse_ticks, input ready);
	modport sink (input valid, kind, pulse_ticks, output ready);
endinterface

interface irpw_out_if;
	import irpw_pkg::*;
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_word;
	logic [CODE_W-1:0]  ended_by;

	modport source (output valid, frame_word, ended_by, input ready);
	modport sink (input valid, frame_word, ended_by, output ready);
endinterface

`default_nettype wire

[hw/rtl/irpw_front.sv]
// ----------------------------------------------------------------------------
// irpw_front
// Holds the window registers, classifies each beat and pushes its class.
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_front #(
	parameter int SPIKE_MAX = irpw_pkg::DEF_SPIKE_MAX
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [irpw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [irpw_pkg::CFG_W-1:0] cfg_wdata,
	irpw_in_if.sink                         in_ch,
	input  wire irpw_pkg::q_stat_t          q_stat,
	output logic                            push,
	output irpw_pkg::q_entry_t              push_entry
);
	import irpw_pkg::*;

	localparam logic [TICK_W-1:0] SPIKE_LIM = TICK_W'(SPIKE_MAX);

	logic [CFG_W-1:0] win_q [NUM_CFG];
	logic             in_one, in_two, in_three, in_six;
	logic [TICK_W-1:0] t;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				win_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we) begin
			win_q[cfg_idx] <= cfg_wdata;
		end
	end

	// window compares
	assign t        = in_ch.pulse_ticks;
	assign in_one   = (win_q[REG_ONE_T_MIN] <= t) && (t <= win_q[REG_ONE_T_MAX]);
	assign in_two   = (win_q[REG_TWO_T_MIN] <= t) && (t <= win_q[REG_TWO_T_MAX]);
	assign in_three = (win_q[REG_THREE_T_MIN] <= t) && (t <= win_q[REG_THREE_T_MAX]);
	assign in_six   = (win_q[REG_SIX_T_MIN] <= t) && (t <= win_q[REG_SIX_T_MAX]);

	// class in priority order
	always_comb begin
		if (in_ch.kind)
			push_entry.cls = CLS_IDLE;
		else if (in_one)
			push_entry.cls = CLS_ONE;
		else if (in_two)
			push_entry.cls = CLS_TWO;
		else if (in_three)
			push_entry.cls = CLS_THREE;
		else if (in_six)
			push_entry.cls = CLS_SIX;
		else if (t <= SPIKE_LIM)
			push_entry.cls = CLS_SPIKE;
		else
			push_entry.cls = CLS_LONG;
	end

	// beat handshake
	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;

endmodule

`default_nettype wire

[hw/rtl/irpw_queue.sv]
// ----------------------------------------------------------------------------
// irpw_queue
// Short class queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire irpw_pkg::q_entry_t push_entry,
	input  wire logic               pop,
	output irpw_pkg::q_entry_t      head,
	output irpw_pkg::q_stat_t       stat
);
	import irpw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	q_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)  rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (do_pop && !do_push)
				cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/irpw_back.sv]
// ----------------------------------------------------------------------------
// irpw_back
// Applies classes to the capture state and registers frame results.
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_back #(
	parameter int RELEASE_TICKS = irpw_pkg::DEF_RELEASE_TICKS,
	parameter int CAPTURE_BITS  = irpw_pkg::DEF_CAPTURE_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire irpw_pkg::q_entry_t head,
	input  wire irpw_pkg::q_stat_t  q_stat,
	output logic                    pop,
	irpw_out_if.source              out_ch
);
	import irpw_pkg::*;

	localparam logic [CD_W-1:0] CD_LOAD = CD_W'(RELEASE_TICKS);

	logic [CAPTURE_BITS-1:0] cap_q, cap_nxt, cap_push, cap_close;
	logic                    lvl_q, lvl_nxt;
	logic [COUNT_W-1:0]      cnt_q, cnt_nxt;
	logic [CD_W-1:0]         cd_q, cd_nxt, cd_dec;
	logic [SHIFT_W-1:0]      n_push, n_close;
	logic [COUNT_W:0]        cnt_sum;
	logic                    emit;
	logic [FRAME_W-1:0]      word;
	logic [CODE_W-1:0]       code;
	logic                    out_valid_q;
	logic [FRAME_W-1:0]      out_word_q;
	logic [CODE_W-1:0]       out_code_q;

	// shift n copies of the level into the capture
	function automatic logic [CAPTURE_BITS-1:0] shift_in(
		input logic [CAPTURE_BITS-1:0] cap,
		input logic                    lvl,
		input logic [SHIFT_W-1:0]      n
	);
		logic [CAPTURE_BITS-1:0] fill;
		fill     = ~({CAPTURE_BITS{1'b1}} << n);
		shift_in = (cap << n) | (lvl ? fill : '0);
	endfunction

	// pulse lengths in half-bits
	always_comb begin
		case (head.cls)
			CLS_ONE:   n_push = 3'd1;
			CLS_TWO:   n_push = 3'd2;
			CLS_THREE: n_push = 3'd3;
			CLS_SIX:   n_push = 3'd6;
			default:   n_push = 3'd0;
		endcase
	end

	assign n_close   = (cnt_q == FULL_FRAME) ? 3'd7 : 3'd6;
	assign cap_push  = shift_in(cap_q, lvl_q, n_push);
	assign cap_close = shift_in(cap_q, lvl_q, n_close);
	assign cnt_sum   = {1'b0, cnt_q} + {{(COUNT_W + 1 - SHIFT_W){1'b0}}, n_push};
	assign cd_dec    = CD_W'(cd_q - 1'b1);

	// next state and result of the head class
	always_comb begin
		cap_nxt = cap_q;
		lvl_nxt = lvl_q;
		cnt_nxt = cnt_q;
		cd_nxt  = cd_q;
		emit    = 1'b0;
		word    = FRAME_W'(cap_close);
		code    = END_PULSE;
		case (head.cls)
			CLS_ONE, CLS_TWO, CLS_THREE, CLS_SIX: begin
				cap_nxt = cap_push;
				cnt_nxt = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
				lvl_nxt = !lvl_q;
			end
			CLS_SPIKE: begin
			end
			CLS_LONG: begin
				emit    = (cap_close != '0);
				cap_nxt = '0;
				cnt_nxt = '0;
				lvl_nxt = 1'b1;
			end
			CLS_IDLE: begin
				if (cap_q != '0) begin
					emit    = (cap_close != '0);
					code    = END_IDLE;
					cap_nxt = '0;
					cnt_nxt = '0;
					lvl_nxt = 1'b0;
					cd_nxt  = CD_LOAD;
				end else if (cd_q != '0) begin
					cd_nxt = cd_dec;
					if (cd_dec == '0) begin
						emit    = 1'b1;
						word    = RELEASE_WORD;
						code    = END_RELEASE;
						cnt_nxt = '0;
						lvl_nxt = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// take the head when the output register frees up
	assign pop = !q_stat.empty && (!out_valid_q || out_ch.ready);

	// capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			lvl_q <= 1'b0;
			cnt_q <= '0;
			cd_q  <= '0;
		end else if (pop) begin
			cap_q <= cap_nxt;
			lvl_q <= lvl_nxt;
			cnt_q <= cnt_nxt;
			cd_q  <= cd_nxt;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_word_q <= word;
			out_code_q <= code;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.frame_word = out_word_q;
	assign out_ch.ended_by   = out_code_q;

endmodule

`default_nettype wire

[hw/rtl/ir_pulse_width_frame_capture_top.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_capture_top
// Infrared pulse-width frame capture: classifies pulse widths into half-bit
// runs, builds frames in a shift register and emits them with an end code.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                      | handshake
//  in_ch    | in  | kind, pulse_ticks            | valid / ready
//  out_ch   | out | frame_word, ended_by         | valid / ready
//  cfg      | in  | cfg_idx, cfg_wdata           | cfg_we, no stall
//
//  one beat per cycle while the class queue is not full; a beat's result, if any,
//  passes through the class queue, then is held in the output register
//  in_ch stalls only when the four-entry class queue is full
//  the back end stalls only while a result sits in the output register unread
//  arst_n clears capture state, queue and output valid; windows load defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_frame_capture_top #(
	parameter int SPIKE_MAX     = irpw_pkg::DEF_SPIKE_MAX,
	parameter int RELEASE_TICKS = irpw_pkg::DEF_RELEASE_TICKS,
	parameter int CAPTURE_BITS  = irpw_pkg::DEF_CAPTURE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [irpw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [irpw_pkg::CFG_W-1:0]     cfg_wdata,
	irpw_in_if.sink                             in_ch,
	irpw_out_if.source                          out_ch
);
	import irpw_pkg::*;

	logic     push, pop;
	q_entry_t push_entry, head;
	q_stat_t  q_stat;

	// classification
	irpw_front #(
		.SPIKE_MAX (SPIKE_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// class queue
	irpw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// frame building
	irpw_back #(
		.RELEASE_TICKS (RELEASE_TICKS),
		.CAPTURE_BITS  (CAPTURE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// checks
`include "assert_macros.svh"

	`IRPW_ASSERT_IMP(a_release_word, out_ch.valid && (out_ch.ended_by == END_RELEASE), out_ch.frame_word == RELEASE_WORD, "release beat without release word")
	`IRPW_ASSERT_IMP(a_no_zero_frame, out_ch.valid && (out_ch.ended_by != END_RELEASE), out_ch.frame_word != '0, "zero frame emitted")
	`IRPW_ASSERT_IMP(a_queue_stat, q_stat.full, !q_stat.empty, "queue both full and empty")
	`IRPW_ASSERT_NXT(a_push_lands, push, !q_stat.empty, "accepted beat missing from queue")

endmodule

`default_nettype wire
